### rtl/kvlt_pkg.sv
// ----------------------------------------------------------------------------
// kvlt_pkg
// shared types, codes and character helpers for the key/value line tokenizer
// ----------------------------------------------------------------------------
package kvlt_pkg;

  localparam int LINE_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam int LNUM_W          = 16;

  // result kinds
  localparam logic [2:0] KIND_NAME  = 3'd0;
  localparam logic [2:0] KIND_VALUE = 3'd1;
  localparam logic [2:0] KIND_PAIR  = 3'd2;
  localparam logic [2:0] KIND_INCL  = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  // error codes
  localparam logic [2:0] ERR_NAME_LONG  = 3'd0;
  localparam logic [2:0] ERR_NO_NAME    = 3'd1;
  localparam logic [2:0] ERR_EOL_NO_EQ  = 3'd2;
  localparam logic [2:0] ERR_JUNK       = 3'd3;
  localparam logic [2:0] ERR_VALUE_LONG = 3'd4;
  localparam logic [2:0] ERR_OPEN_QUOTE = 3'd5;

  // configuration register indexes
  localparam logic CFG_NAME_LIMIT  = 1'b0;
  localparam logic CFG_VALUE_LIMIT = 1'b1;

  // characters
  localparam logic [7:0] CH_NL    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_UNDER = 8'h5f;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  localparam logic [2:0] INCL_LEN = 3'd7;

  typedef struct packed {
    logic [7:0] byte_req;
    logic       end_of_file;
  } in_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        char_out;
    logic [2:0]        error_code;
    logic [LNUM_W-1:0] line_number;
    logic              last;
  } out_t;

  // one queue entry: the results of one input item
  typedef struct packed {
    logic two;
    out_t r0;
    out_t r1;
  } ent_t;

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_name_char(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CH_UNDER) || (c == CH_MINUS);
  endfunction

  // letters of the word include
  function automatic logic [7:0] incl_char(input logic [2:0] idx);
    logic [7:0] r;
    unique case (idx)
      3'd0:    r = 8'h69;
      3'd1:    r = 8'h6e;
      3'd2:    r = 8'h63;
      3'd3:    r = 8'h6c;
      3'd4:    r = 8'h75;
      3'd5:    r = 8'h64;
      3'd6:    r = 8'h65;
      default: r = 8'h00;
    endcase
    return r;
  endfunction

endpackage

### rtl/kvlt_front.sv
// ----------------------------------------------------------------------------
// kvlt_front
// classifies each byte, runs the line state machine and forms its results
// ----------------------------------------------------------------------------
module kvlt_front #(
  parameter int LINE_BITS = kvlt_pkg::LINE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           acc,
  input  kvlt_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_wdata,
  output logic           push,
  output kvlt_pkg::ent_t push_ent
);
  import kvlt_pkg::*;

  localparam logic [2:0] M_START   = 3'd0;
  localparam logic [2:0] M_COMMENT = 3'd1;
  localparam logic [2:0] M_NAME    = 3'd2;
  localparam logic [2:0] M_AFTER   = 3'd3;
  localparam logic [2:0] M_VALUE   = 3'd4;
  localparam logic [2:0] M_INCVAL  = 3'd5;
  localparam logic [2:0] M_HALT    = 3'd6;

  logic [7:0]           name_limit_r, value_limit_r;
  logic [2:0]           mode_r, mode_nxt;
  logic [7:0]           name_count_r, name_count_nxt;
  logic [7:0]           value_count_r, value_count_nxt;
  logic                 quote_r, quote_nxt;
  logic                 vcmt_r, vcmt_nxt;
  logic                 sp_r, sp_nxt;
  logic [2:0]           incm_r, incm_nxt;
  logic [LINE_BITS-1:0] line_r, line_nxt, res_line;

  logic [7:0] c;
  logic       eof, nl;
  logic       go_name, go_after, go_value, inc_v;
  logic [7:0] nc, vc;
  logic [2:0] im;
  logic       q, cm, sp, add2;
  logic [8:0] sum;
  logic       do_push, two;
  logic [2:0] k0, e0;
  logic [7:0] ch0;

  assign c   = in_data.byte_req;
  assign eof = in_data.end_of_file;
  assign nl  = !eof && (c == CH_NL);

  always_comb begin
    mode_nxt        = mode_r;
    name_count_nxt  = name_count_r;
    value_count_nxt = value_count_r;
    quote_nxt       = quote_r;
    vcmt_nxt        = vcmt_r;
    sp_nxt          = sp_r;
    incm_nxt        = incm_r;
    line_nxt        = line_r;
    res_line        = line_r;
    go_name  = 1'b0;
    go_after = 1'b0;
    go_value = 1'b0;
    inc_v    = (mode_r == M_INCVAL);
    nc  = name_count_r;
    im  = incm_r;
    vc  = value_count_r;
    q   = quote_r;
    cm  = vcmt_r;
    sp  = sp_r;
    add2 = 1'b0;
    sum  = '0;
    do_push = 1'b0;
    two = 1'b0;
    k0  = KIND_NAME;
    e0  = '0;
    ch0 = '0;

    if (acc && (mode_r < M_HALT)) begin
      if (nl && (line_r != '1)) begin
        line_nxt = line_r + LINE_BITS'(1);
      end
      res_line = line_nxt;

      unique case (mode_r)
        M_START: begin
          if (eof) begin
            mode_nxt = M_START;
            line_nxt = LINE_BITS'(1);
          end else if (is_space(c)) begin
            mode_nxt = M_START;
          end else if (c == CH_HASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            nc = '0;
            im = '0;
            go_name = 1'b1;
          end
        end
        M_COMMENT: begin
          if (eof) begin
            mode_nxt = M_START;
            line_nxt = LINE_BITS'(1);
          end else if (nl) begin
            mode_nxt = M_START;
          end
        end
        M_NAME:   go_name  = 1'b1;
        M_AFTER:  go_after = 1'b1;
        M_VALUE,
        M_INCVAL: go_value = 1'b1;
        default:  mode_nxt = mode_r;
      endcase

      // name characters and the end of a name
      if (go_name) begin
        if (!eof && is_name_char(c)) begin
          if (nc == name_limit_r) begin
            mode_nxt = M_HALT;
            do_push = 1'b1;
            k0 = KIND_ERR;
            e0 = ERR_NAME_LONG;
          end else begin
            incm_nxt = im;
            if ((im == nc[2:0]) && (nc < 8'd7) && (c == incl_char(nc[2:0]))) begin
              incm_nxt = im + 3'd1;
            end
            do_push = 1'b1;
            k0  = KIND_NAME;
            ch0 = c;
            name_count_nxt = nc + 8'd1;
            mode_nxt = M_NAME;
          end
        end else if (nc == 8'd0) begin
          mode_nxt = M_HALT;
          do_push = 1'b1;
          k0 = KIND_ERR;
          e0 = ERR_NO_NAME;
        end else if ((im == INCL_LEN) && (nc == 8'd7)) begin
          // include takes its value without =
          mode_nxt = M_INCVAL;
          inc_v = 1'b1;
          vc = '0;
          q  = 1'b0;
          cm = 1'b0;
          sp = 1'b0;
          go_value = 1'b1;
        end else begin
          mode_nxt = M_AFTER;
          go_after = 1'b1;
        end
      end

      // between name and =
      if (go_after) begin
        if (eof || nl) begin
          mode_nxt = M_HALT;
          do_push = 1'b1;
          k0 = KIND_ERR;
          e0 = ERR_EOL_NO_EQ;
        end else if (c == CH_EQ) begin
          mode_nxt        = M_VALUE;
          value_count_nxt = '0;
          quote_nxt       = 1'b0;
          vcmt_nxt        = 1'b0;
          sp_nxt          = 1'b0;
        end else if (!is_space(c)) begin
          mode_nxt = M_HALT;
          do_push = 1'b1;
          k0 = KIND_ERR;
          e0 = ERR_JUNK;
        end
      end

      // value characters
      if (go_value) begin
        value_count_nxt = vc;
        quote_nxt       = q;
        vcmt_nxt        = cm;
        sp_nxt          = sp;
        if (eof || nl) begin
          do_push = 1'b1;
          if (q) begin
            mode_nxt = M_HALT;
            k0 = KIND_ERR;
            e0 = ERR_OPEN_QUOTE;
          end else begin
            k0 = inc_v ? KIND_INCL : KIND_PAIR;
            mode_nxt = M_START;
            if (eof) begin
              name_count_nxt  = '0;
              value_count_nxt = '0;
              quote_nxt       = 1'b0;
              vcmt_nxt        = 1'b0;
              sp_nxt          = 1'b0;
              incm_nxt        = '0;
              line_nxt        = LINE_BITS'(1);
            end
          end
        end else begin
          vcmt_nxt = cm || (c == CH_HASH);
          if ((is_space(c) && !q) || vcmt_nxt) begin
            sp_nxt = 1'b1;
          end else if (c == CH_QUOTE) begin
            quote_nxt = !q;
          end else begin
            add2 = sp && (vc != 8'd0);
            sum  = {1'b0, vc} + (add2 ? 9'd2 : 9'd1);
            do_push = 1'b1;
            if (sum > {1'b0, value_limit_r}) begin
              mode_nxt = M_HALT;
              k0 = KIND_ERR;
              e0 = ERR_VALUE_LONG;
            end else begin
              two = add2;
              k0  = KIND_VALUE;
              ch0 = add2 ? CH_SPACE : c;
              value_count_nxt = sum[7:0];
              sp_nxt = 1'b0;
            end
          end
        end
      end
    end
  end

  assign push = do_push;

  always_comb begin
    push_ent.two            = two;
    push_ent.r0.kind        = k0;
    push_ent.r0.char_out    = ch0;
    push_ent.r0.error_code  = e0;
    push_ent.r0.line_number = LNUM_W'(res_line);
    push_ent.r0.last        = !two;
    push_ent.r1.kind        = KIND_VALUE;
    push_ent.r1.char_out    = c;
    push_ent.r1.error_code  = '0;
    push_ent.r1.line_number = LNUM_W'(res_line);
    push_ent.r1.last        = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      name_limit_r  <= 8'd255;
      value_limit_r <= 8'd255;
      mode_r        <= M_START;
      name_count_r  <= '0;
      value_count_r <= '0;
      quote_r       <= 1'b0;
      vcmt_r        <= 1'b0;
      sp_r          <= 1'b0;
      incm_r        <= '0;
      line_r        <= LINE_BITS'(1);
    end else begin
      if (cfg_we && (cfg_index == CFG_NAME_LIMIT)) begin
        name_limit_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == CFG_VALUE_LIMIT)) begin
        value_limit_r <= cfg_wdata;
      end
      mode_r        <= mode_nxt;
      name_count_r  <= name_count_nxt;
      value_count_r <= value_count_nxt;
      quote_r       <= quote_nxt;
      vcmt_r        <= vcmt_nxt;
      sp_r          <= sp_nxt;
      incm_r        <= incm_nxt;
      line_r        <= line_nxt;
    end
  end

endmodule

### rtl/kvlt_queue.sv
// ----------------------------------------------------------------------------
// kvlt_queue
// short fifo of result entries between the front and the back
// ----------------------------------------------------------------------------
module kvlt_queue #(
  parameter int DEPTH = kvlt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  kvlt_pkg::ent_t wr_ent,
  input  logic           pop,
  output kvlt_pkg::ent_t rd_ent,
  output logic           not_full,
  output logic           not_empty
);
  import kvlt_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  ent_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign not_full  = (cnt_r != CNT_FULL);
  assign not_empty = (cnt_r != '0);
  assign rd_ent    = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

### rtl/kvlt_back.sv
// ----------------------------------------------------------------------------
// kvlt_back
// unpacks queue entries into single results behind an output register
// ----------------------------------------------------------------------------
module kvlt_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_not_empty,
  input  kvlt_pkg::ent_t q_ent,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output kvlt_pkg::out_t out_data
);
  import kvlt_pkg::*;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;
  logic pend_r, pend_nxt;
  out_t second_r;
  logic load;

  assign load = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    pend_nxt      = pend_r;
    q_pop         = 1'b0;
    if (load) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = second_r;
        pend_nxt      = 1'b0;
      end else if (q_not_empty) begin
        q_pop         = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = q_ent.r0;
        pend_nxt      = q_ent.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (q_pop) begin
      second_r <= q_ent.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/key_value_line_tokenizer.sv
// ----------------------------------------------------------------------------
// key_value_line_tokenizer
// streaming tokenizer for name=value configuration lines
// ----------------------------------------------------------------------------
// Takes one byte (or an end-of-file mark) per input transfer and emits name
// characters, value characters, a completion mark per pair or include line
// and at most one fatal error, after which the block swallows input until
// reset. The front end takes one input transfer every cycle while its queue
// has room; each byte yields zero, one or two results, and the back end
// delivers one result per cycle while the sink is ready, so input runs at
// one byte per cycle except where a collapsed space plus a character come
// out as two results. Results pass through the queue entry and then the
// output register. Limits must be written through the cfg port only while
// the block is idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer #(
  parameter int LINE_BITS   = kvlt_pkg::LINE_BITS_DEF,
  parameter int QUEUE_DEPTH = kvlt_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  // input byte channel
  input  logic           in_valid,
  output logic           in_ready,
  input  kvlt_pkg::in_t  in_data,
  // result channel
  output logic           out_valid,
  input  logic           out_ready,
  output kvlt_pkg::out_t out_data,
  // configuration write port
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_wdata
);
  import kvlt_pkg::*;

  logic acc;
  logic push, pop;
  logic q_not_full, q_not_empty;
  ent_t push_ent, head_ent;

  // input transfer whenever the queue can take a full entry
  assign in_ready = q_not_full;
  assign acc      = in_valid && in_ready;

  // front: byte classification and the line state machine
  kvlt_front #(
    .LINE_BITS(LINE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .push     (push),
    .push_ent (push_ent)
  );

  // decoupling queue, one entry holds all results of one byte
  kvlt_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_ent   (push_ent),
    .pop      (pop),
    .rd_ent   (head_ent),
    .not_full (q_not_full),
    .not_empty(q_not_empty)
  );

  // back: serialises entries onto the result channel
  kvlt_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_ent      (head_ent),
    .q_pop      (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

### bench/key_value_line_tokenizer_tb.sv
// ----------------------------------------------------------------------------
// key_value_line_tokenizer_tb
// self-checking bench for the name=value line tokenizer
// ----------------------------------------------------------------------------
// A byte-level model of the tokenizer runs beside the block and turns every
// accepted input transfer into the results it should cause. Each result
// transfer is compared field by field with the oldest of these. Directed
// lines come first, then steered random text under several limit settings
// and flow-control phases. The run ends with one fatal error, chosen at
// random, followed by traffic that a halted block must swallow.
// ----------------------------------------------------------------------------
module key_value_line_tokenizer_tb;
  import kvlt_pkg::*;

  localparam int QUIET_LIMIT = 2000;  // cycles with no transfer at all
  localparam int TAIL_CYCLES = 20;    // settle time after the last result
  localparam int PRINT_LIMIT = 40;

  typedef enum logic [2:0] {
    ST_START, ST_COMMENT, ST_NAME, ST_AFTER, ST_VALUE, ST_INCVAL, ST_HALT
  } tok_mode_e;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_e;

  typedef struct packed {
    tok_mode_e   mode;
    logic [7:0]  name_cnt;
    logic [7:0]  value_cnt;
    logic        in_quote;
    logic        in_cmt;
    logic        space_pend;
    logic [3:0]  inc_match;
    logic [15:0] line_cnt;
  } tok_state_t;

  // model state after one byte plus the results that byte causes
  typedef struct packed {
    tok_state_t st;
    logic [1:0] n;
    out_t       r0;
    out_t       r1;
  } tok_step_t;

  localparam logic [55:0] INC_WORD = "include";

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic cfg_index = CFG_NAME_LIMIT;
  logic [7:0] cfg_wdata = 8'd0;

  tok_state_t tok_state;
  logic [7:0] name_limit_q = 8'd255;
  logic [7:0] value_limit_q = 8'd255;
  out_t expected_tokens[$];
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int src_idle_pct = 0;
  int sink_stall_pct = 0;

  key_value_line_tokenizer dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // tokenizer model
  // --------------------------------------------------------------------------

  function automatic bit is_blank(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_ident_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == CH_UNDER || c == CH_MINUS;
  endfunction

  function automatic tok_state_t idle_state();
    tok_state_t s;
    s = '0;
    s.mode = ST_START;
    s.line_cnt = 16'd1;
    return s;
  endfunction

  function automatic void add_result(inout tok_step_t r, input logic [2:0] k,
                                     input logic [7:0] ch, input logic [2:0] e);
    out_t o;
    o.kind = k;
    o.char_out = ch;
    o.error_code = e;
    o.line_number = r.st.line_cnt;
    o.last = 1'b0;
    if (r.n == 2'd0) r.r0 = o;
    else r.r1 = o;
    r.n = r.n + 2'd1;
  endfunction

  // any error halts the block until reset
  function automatic void raise_error(inout tok_step_t r, input logic [2:0] e);
    add_result(r, KIND_ERR, 8'h00, e);
    r.st.mode = ST_HALT;
  endfunction

  function automatic void open_value(inout tok_step_t r, input tok_mode_e m);
    r.st.mode = m;
    r.st.value_cnt = 8'd0;
    r.st.in_quote = 1'b0;
    r.st.in_cmt = 1'b0;
    r.st.space_pend = 1'b0;
  endfunction

  function automatic void value_byte(inout tok_step_t r, input logic [7:0] c,
                                     input bit eof, input logic [7:0] vlim);
    int add;
    if (eof || c == CH_NL) begin
      if (r.st.in_quote) begin
        raise_error(r, ERR_OPEN_QUOTE);
        return;
      end
      add_result(r, (r.st.mode == ST_INCVAL) ? KIND_INCL : KIND_PAIR, 8'h00, 3'd0);
      if (eof) r.st = idle_state();
      else r.st.mode = ST_START;
      return;
    end
    // a hash opens a comment even between quotes
    if (c == CH_HASH) r.st.in_cmt = 1'b1;
    if ((is_blank(c) && !r.st.in_quote) || r.st.in_cmt) begin
      r.st.space_pend = 1'b1;
      return;
    end
    if (c == CH_QUOTE) begin
      r.st.in_quote = ~r.st.in_quote;
      return;
    end
    // a pending space only turns into a separator once the value has begun
    add = (r.st.space_pend && r.st.value_cnt != 8'd0) ? 2 : 1;
    if (int'(r.st.value_cnt) + add > int'(vlim)) begin
      raise_error(r, ERR_VALUE_LONG);
      return;
    end
    if (add == 2) begin
      add_result(r, KIND_VALUE, CH_SPACE, 3'd0);
      r.st.value_cnt = r.st.value_cnt + 8'd1;
    end
    r.st.space_pend = 1'b0;
    add_result(r, KIND_VALUE, c, 3'd0);
    r.st.value_cnt = r.st.value_cnt + 8'd1;
  endfunction

  function automatic void after_byte(inout tok_step_t r, input logic [7:0] c,
                                     input bit eof);
    if (eof || c == CH_NL) raise_error(r, ERR_EOL_NO_EQ);
    else if (c == CH_EQ) open_value(r, ST_VALUE);
    else if (!is_blank(c)) raise_error(r, ERR_JUNK);
  endfunction

  function automatic void name_byte(inout tok_step_t r, input logic [7:0] c,
                                    input bit eof, input logic [7:0] nlim,
                                    input logic [7:0] vlim);
    int idx;
    if (!eof && is_ident_char(c)) begin
      if (r.st.name_cnt == nlim) begin
        raise_error(r, ERR_NAME_LONG);
        return;
      end
      idx = int'(r.st.name_cnt);
      if (int'(r.st.inc_match) == idx && idx < 7 && c == INC_WORD[8*(6-idx) +: 8])
        r.st.inc_match = r.st.inc_match + 4'd1;
      add_result(r, KIND_NAME, c, 3'd0);
      r.st.name_cnt = r.st.name_cnt + 8'd1;
      r.st.mode = ST_NAME;
      return;
    end
    if (r.st.name_cnt == 8'd0) begin
      raise_error(r, ERR_NO_NAME);
      return;
    end
    // exactly the word include: the value starts with this very byte
    if (r.st.inc_match == 4'd7 && r.st.name_cnt == 8'd7) begin
      open_value(r, ST_INCVAL);
      value_byte(r, c, eof, vlim);
    end else begin
      r.st.mode = ST_AFTER;
      after_byte(r, c, eof);
    end
  endfunction

  function automatic tok_step_t tokenize_byte(input tok_state_t s, input in_t item,
                                              input logic [7:0] nlim,
                                              input logic [7:0] vlim);
    tok_step_t r;
    logic [7:0] c;
    bit eof;
    r = '0;
    r.st = s;
    c = item.byte_req;
    eof = item.end_of_file;
    if (s.mode == ST_HALT) return r;
    // newline is counted before any result of this byte is formed
    if (!eof && c == CH_NL && r.st.line_cnt != 16'hffff)
      r.st.line_cnt = r.st.line_cnt + 16'd1;
    case (r.st.mode)
      ST_START: begin
        if (eof) r.st = idle_state();
        else if (is_blank(c)) ;
        else if (c == CH_HASH) r.st.mode = ST_COMMENT;
        else begin
          r.st.name_cnt = 8'd0;
          r.st.inc_match = 4'd0;
          name_byte(r, c, eof, nlim, vlim);
        end
      end
      ST_COMMENT: begin
        if (eof) r.st = idle_state();
        else if (c == CH_NL) r.st.mode = ST_START;
      end
      ST_NAME:  name_byte(r, c, eof, nlim, vlim);
      ST_AFTER: after_byte(r, c, eof);
      default:  value_byte(r, c, eof, vlim);
    endcase
    if (r.n == 2'd1) r.r0.last = 1'b1;
    if (r.n == 2'd2) r.r1.last = 1'b1;
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_LIMIT) $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  task automatic set_flow(input flow_e f);
    src_idle_pct = (f == FLOW_SRC_IDLE) ? 63 : (f == FLOW_BOTH) ? 10 : 0;
    sink_stall_pct = (f == FLOW_SINK_STALL) ? 63 : (f == FLOW_BOTH) ? 10 : 0;
  endtask

  // one input transfer; the model runs at the accepting edge
  task automatic send_item(input logic [7:0] b, input bit eof);
    in_t item;
    tok_step_t step;
    item.byte_req = b;
    item.end_of_file = eof;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step = tokenize_byte(tok_state, item, name_limit_q, value_limit_q);
    tok_state = step.st;
    if (step.n >= 2'd1) expected_tokens.push_back(step.r0);
    if (step.n == 2'd2) expected_tokens.push_back(step.r1);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  // stop sending, let every result out, then allow for a byte still in flight
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_limits(input logic [7:0] nlim, input logic [7:0] vlim);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_NAME_LIMIT;
    cfg_wdata <= nlim;
    @(posedge clk);
    cfg_index <= CFG_VALUE_LIMIT;
    cfg_wdata <= vlim;
    @(posedge clk);
    cfg_we <= 1'b0;
    name_limit_q = nlim;
    value_limit_q = vlim;
  endtask

  function automatic logic [7:0] rand_ident_char();
    int n;
    n = $urandom_range(0, 63);
    if (n < 26) return 8'(int'("a") + n);
    if (n < 52) return 8'(int'("A") + n - 26);
    if (n < 62) return 8'(int'("0") + n - 52);
    return (n == 62) ? CH_UNDER : CH_MINUS;
  endfunction

  function automatic logic [7:0] rand_blank();
    return ($urandom_range(0, 2) == 0) ? 8'($urandom_range(9, 13)) : CH_SPACE;
  endfunction

  // byte that moves the model towards the next line without any error
  function automatic logic [7:0] safe_byte(input tok_state_t s);
    case (s.mode)
      ST_START:          return CH_SPACE;
      ST_COMMENT:        return CH_NL;
      ST_NAME, ST_AFTER: return CH_EQ;
      default:           return s.in_quote ? CH_QUOTE : CH_NL;
    endcase
  endfunction

  // candidate byte shaped by the current mode; mostly well-formed text
  function automatic in_t rand_candidate(input tok_state_t s);
    in_t it;
    int r;
    int idx;
    it.byte_req = 8'($urandom_range(0, 255));
    it.end_of_file = 1'b0;
    r = $urandom_range(0, 99);
    idx = int'(s.name_cnt);
    case (s.mode)
      ST_START, ST_NAME: begin
        if (s.mode == ST_START) begin
          if (r < 55) r = 0;
          else if (r < 70) it.byte_req = rand_blank();
          else if (r < 80) it.byte_req = CH_NL;
          else if (r < 90) it.byte_req = CH_HASH;
          else if (r < 93) it.end_of_file = 1'b1;
        end else begin
          if (r >= 55 && r < 65) it.byte_req = rand_blank();
          else if (r >= 65 && r < 90) it.byte_req = CH_EQ;
          else if (r >= 90) ;
        end
        if (r < 55) begin
          if (s.mode == ST_START) idx = 0;
          // lean towards spelling the word include
          if ((s.mode == ST_START || int'(s.inc_match) == idx) && idx < 7 &&
              $urandom_range(0, 99) < 80)
            it.byte_req = INC_WORD[8*(6-idx) +: 8];
          else
            it.byte_req = rand_ident_char();
        end
      end
      ST_COMMENT: begin
        if (r < 12) it.byte_req = CH_NL;
        else if (r < 14) it.end_of_file = 1'b1;
      end
      ST_AFTER: begin
        it.byte_req = (r < 40) ? rand_blank() : CH_EQ;
      end
      default: begin
        if (r < 8) it.byte_req = CH_NL;
        else if (r < 10) it.end_of_file = 1'b1;
        else if (r < 20) it.byte_req = rand_blank();
        else if (r < 26) it.byte_req = CH_QUOTE;
        else if (r < 29) it.byte_req = CH_HASH;
        else if (r < 70) it.byte_req = 8'($urandom_range(33, 126));
        // a comment opened inside quotes could only end in an error
        if (s.in_quote && !it.end_of_file && it.byte_req == CH_HASH)
          it.byte_req = "q";
      end
    endcase
    return it;
  endfunction

  task automatic send_random(input int count);
    in_t it;
    tok_step_t trial;
    for (int i = 0; i < count; i++) begin
      it = rand_candidate(tok_state);
      trial = tokenize_byte(tok_state, it, name_limit_q, value_limit_q);
      if (trial.st.mode == ST_HALT) begin
        it.byte_req = safe_byte(tok_state);
        it.end_of_file = 1'b0;
      end
      send_item(it.byte_req, it.end_of_file);
    end
  endtask

  task automatic close_line();
    while (tok_state.mode != ST_START) send_item(safe_byte(tok_state), 1'b0);
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // comment line, then a pair with quotes, collapsed blanks and a trailing comment
  task automatic test_pairs_and_comments();
    send_text("# x\n");
    send_text(" K_-9 =\t\"a  b\"  c #\"q\n");
  endtask

  // include without '=', end of file in a value, in a comment and at line start
  task automatic test_include_and_eof();
    send_text("include  v w\n");
    send_text("a=1");
    send_item(8'hff, 1'b1);
    send_text("z=");
    send_item(8'h00, 1'b0);
    send_item(8'hff, 1'b0);
    send_item(CH_NL, 1'b0);
    send_item("a", 1'b1);
    send_text("#c");
    send_item(8'h00, 1'b1);
  endtask

  task automatic test_random_traffic();
    logic [7:0] nlim;
    logic [7:0] vlim;
    for (int seg = 0; seg < 12; seg++) begin
      case (seg)
        0: begin nlim = 8'd255; vlim = 8'd255; end
        1: begin nlim = 8'd1;   vlim = 8'd1;   end
        2: begin nlim = 8'd1;   vlim = 8'd255; end
        3: begin nlim = 8'd255; vlim = 8'd1;   end
        default: begin
          nlim = (seg % 2) ? 8'($urandom_range(1, 12)) : 8'($urandom_range(1, 255));
          vlim = (seg % 2) ? 8'($urandom_range(1, 16)) : 8'($urandom_range(1, 255));
        end
      endcase
      set_limits(nlim, vlim);
      set_flow(flow_e'(seg % 4));
      send_random(140);
    end
  endtask

  // only one error fits in a run, since nothing but reset leaves the halt
  task automatic test_fatal_error();
    logic [2:0] code;
    code = 3'($urandom_range(0, 5));
    set_flow(FLOW_BOTH);
    close_line();
    case (code)
      ERR_NAME_LONG: while (tok_state.mode != ST_HALT) send_item("n", 1'b0);
      ERR_NO_NAME:   send_item(CH_EQ, 1'b0);
      ERR_EOL_NO_EQ: begin
        send_text("ab");
        send_item(CH_NL, 1'($urandom_range(0, 1)));
      end
      ERR_JUNK:      send_text("a $");
      ERR_VALUE_LONG: begin
        send_text("v=");
        while (tok_state.mode != ST_HALT) send_item("x", 1'b0);
      end
      default: begin
        send_text("q=\"z");
        send_item(CH_NL, 1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // a halted block takes every transfer and answers none
  task automatic test_halted();
    repeat (30) send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  // --------------------------------------------------------------------------
  // result checking, sink flow control and watchdog
  // --------------------------------------------------------------------------

  always @(posedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        report_mismatch($sformatf("unexpected result %h", out_data));
      end else begin
        want = expected_tokens.pop_front();
        if (out_data.kind !== want.kind)
          report_mismatch($sformatf("kind got %0d expected %0d",
                                    out_data.kind, want.kind));
        if (out_data.char_out !== want.char_out)
          report_mismatch($sformatf("char got %h expected %h",
                                    out_data.char_out, want.char_out));
        if (out_data.error_code !== want.error_code)
          report_mismatch($sformatf("error code got %0d expected %0d",
                                    out_data.error_code, want.error_code));
        if (out_data.line_number !== want.line_number)
          report_mismatch($sformatf("line got %0d expected %0d",
                                    out_data.line_number, want.line_number));
        if (out_data.last !== want.last)
          report_mismatch($sformatf("last got %b expected %b",
                                    out_data.last, want.last));
      end
    end
  end

  // any transfer on either side counts as progress
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    tok_state = idle_state();
    set_flow(FLOW_FREE);
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_pairs_and_comments();
    test_include_and_eof();
    test_random_traffic();
    test_fatal_error();
    test_halted();

    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
